// ===== src/tls_sni_pkg.sv =====
// package for the tls server name extractor
// types, codes and constants shared by the extractor; no dependencies
`default_nettype none

package tls_sni_pkg;

  // largest number of name bytes emitted per packet
  localparam int unsigned MAX_NAME_BYTES_DEF = 255;

  // record content types
  localparam logic [7:0] REC_TYPE_MIN      = 8'd20;
  localparam logic [7:0] REC_TYPE_MAX      = 8'd24;
  localparam logic [7:0] REC_TYPE_HANDSHK  = 8'd22;
  localparam logic [7:0] REC_TYPE_APPDATA  = 8'd23;
  localparam logic [7:0] TLS_MAJOR_MIN     = 8'h03;
  localparam logic [7:0] HS_CLIENT_HELLO   = 8'd1;

  // byte offsets inside the record header and hello prefix
  localparam int unsigned OFFSET_W         = 6;
  localparam logic [OFFSET_W-1:0] OFS_FIRST_HDR  = 6'd2;
  localparam logic [OFFSET_W-1:0] OFS_HS_TYPE    = 6'd5;
  localparam logic [OFFSET_W-1:0] OFS_PREFIX_END = 6'd42;

  // bytes between the server name extension type and the name length
  localparam logic [15:0] SNI_HDR_SKIP     = 16'd5;
  localparam logic [17:0] EXT_HDR_BYTES    = 18'd4;
  localparam logic [15:0] SEARCH_SAT       = 16'hFFFF;

  // result queue
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_FOUND         = 4'd0,
    ST_NOT_TLS       = 4'd1,
    ST_OLD_VERSION   = 4'd2,
    ST_APP_DATA      = 4'd3,
    ST_NOT_HANDSHAKE = 4'd4,
    ST_SHORT         = 4'd5,
    ST_NOT_HELLO     = 4'd6,
    ST_NO_EXT        = 4'd7,
    ST_NO_SNI        = 4'd8,
    ST_NAME_CUT      = 4'd9
  } status_e;

  typedef enum logic [4:0] {
    PH_TYPE      = 5'd0,
    PH_VER_HS    = 5'd1,
    PH_VER_OTHER = 5'd2,
    PH_HDR       = 5'd3,
    PH_SID_LEN   = 5'd4,
    PH_SID_SKIP  = 5'd5,
    PH_CS_HI     = 5'd6,
    PH_CS_LO     = 5'd7,
    PH_CS_SKIP   = 5'd8,
    PH_CM_LEN    = 5'd9,
    PH_CM_SKIP   = 5'd10,
    PH_EXT_HI    = 5'd11,
    PH_EXT_LO    = 5'd12,
    PH_ET_HI     = 5'd13,
    PH_ET_LO     = 5'd14,
    PH_EL_HI     = 5'd15,
    PH_EL_LO     = 5'd16,
    PH_EL_SKIP   = 5'd17,
    PH_SN_SKIP5  = 5'd18,
    PH_NL_HI     = 5'd19,
    PH_NL_LO     = 5'd20,
    PH_NAME      = 5'd21,
    PH_DONE      = 5'd22
  } phase_e;

  typedef enum logic {
    KIND_NAME   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    kind_e      item_kind;
    logic [7:0] name_byte;
    logic       name_final;
    status_e    status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/tls_sni_extractor_top.sv =====
// top level of the tls server name extractor
// byte parser and result queue; depends on tls_sni_pkg
`default_nettype none

// tls server name extractor
//
// in channel: one tcp payload byte per item (in_item_i.data_byte), the last
// byte of a packet carries in_item_i.end_of_packet. the parser checks the
// record header and client hello, skips the fixed prefix, session id,
// cipher suites and compression methods, walks the extensions to the first
// server name extension and emits its name bytes, at most MAX_NAME_BYTES.
// out channel: name byte items (item_kind 0, name_final on the last one)
// and one status item (item_kind 1) per packet, after the packet's last byte.
//
// throughput: one input item per cycle while in_ready_o is high. each byte
// updates the parse state in the cycle it is accepted; its results (none,
// one or two) are registered in a four-entry result queue and leave it in
// order. the queue drains one item per cycle while out_ready_i is high, so
// a byte with two results (a name byte ending the packet) gives two items.
// in_ready_o is high while at least two queue entries are free, so the input
// side keeps flowing while a result waits; when the receiver stalls, results
// pile up and input stalls once three entries are taken, while bytes that
// give no result keep flowing until then.
// reset clears the parser to wait for a record type and empties the queue;
// after each end of packet the parser starts afresh on its own.
module tls_sni_extractor_top
  import tls_sni_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_item_o
);

  localparam int unsigned NameW = $clog2(MAX_NAME_BYTES + 1);

  // parse state
  phase_e              phase_q, phase_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [15:0]         skip_q, skip_d;
  logic [7:0]          acc_q, acc_d;
  logic [15:0]         ext_total_q, ext_total_d;
  logic [15:0]         ext_search_q, ext_search_d;
  logic [NameW-1:0]    name_rem_q, name_rem_d;
  status_e             pkt_status_q, pkt_status_d;

  // result queue
  out_item_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  logic        in_fire;
  logic        out_fire;
  logic [7:0]  b;
  logic        eop;
  logic [15:0] word;
  logic [17:0] search_sum;
  logic [15:0] search_sat;
  logic        name_vld;
  logic        name_fin;
  status_e     end_status;
  out_item_t   name_item;
  out_item_t   status_item;
  logic [1:0]  push_n;

  assign in_ready_o  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign out_item_o  = queue_q[rd_ptr_q];

  assign b    = in_item_i.data_byte;
  assign eop  = in_item_i.end_of_packet;
  assign word = {acc_q, b};

  // searched count grows by the extension length plus its 4 header bytes
  assign search_sum = {2'b00, ext_search_q} + {2'b00, word} + EXT_HDR_BYTES;
  assign search_sat = (search_sum[17:16] != 2'b00) ? SEARCH_SAT : search_sum[15:0];

  // parser: next state for the accepted byte
  always_comb begin
    phase_d      = phase_q;
    offset_d     = offset_q;
    skip_d       = skip_q;
    acc_d        = acc_q;
    ext_total_d  = ext_total_q;
    ext_search_d = ext_search_q;
    name_rem_d   = name_rem_q;
    pkt_status_d = pkt_status_q;
    name_vld     = 1'b0;
    name_fin     = 1'b0;
    end_status   = ST_SHORT;

    if (in_fire) begin
      case (phase_q)
        PH_TYPE: begin
          if (!(b inside {[REC_TYPE_MIN:REC_TYPE_MAX]})) begin
            pkt_status_d = ST_NOT_TLS;
            phase_d      = PH_DONE;
          end else if (b == REC_TYPE_HANDSHK) begin
            phase_d = PH_VER_HS;
          end else begin
            pkt_status_d = (b == REC_TYPE_APPDATA) ? ST_APP_DATA : ST_NOT_HANDSHAKE;
            phase_d      = PH_VER_OTHER;
          end
        end
        PH_VER_HS, PH_VER_OTHER: begin
          if (b < TLS_MAJOR_MIN) begin
            pkt_status_d = ST_OLD_VERSION;
            phase_d      = PH_DONE;
          end else if (phase_q == PH_VER_OTHER) begin
            phase_d = PH_DONE;
          end else begin
            offset_d = OFS_FIRST_HDR;
            phase_d  = PH_HDR;
          end
        end
        PH_HDR: begin
          if (offset_q == OFS_HS_TYPE && b != HS_CLIENT_HELLO) begin
            pkt_status_d = ST_NOT_HELLO;
            phase_d      = PH_DONE;
          end else begin
            if (offset_q >= OFS_PREFIX_END) begin
              phase_d = PH_SID_LEN;
            end
            offset_d = offset_q + OFFSET_W'(1);
          end
        end
        PH_SID_LEN: begin
          skip_d  = {8'd0, b};
          phase_d = (b == 8'd0) ? PH_CS_HI : PH_SID_SKIP;
        end
        PH_CS_HI: begin
          acc_d   = b;
          phase_d = PH_CS_LO;
        end
        PH_EXT_HI: begin
          acc_d   = b;
          phase_d = PH_EXT_LO;
        end
        PH_ET_HI: begin
          acc_d   = b;
          phase_d = PH_ET_LO;
        end
        PH_EL_HI: begin
          acc_d   = b;
          phase_d = PH_EL_LO;
        end
        PH_NL_HI: begin
          acc_d   = b;
          phase_d = PH_NL_LO;
        end
        PH_CS_LO: begin
          skip_d  = word;
          phase_d = (word == 16'd0) ? PH_CM_LEN : PH_CS_SKIP;
        end
        PH_CM_LEN: begin
          skip_d  = {8'd0, b};
          phase_d = (b == 8'd0) ? PH_EXT_HI : PH_CM_SKIP;
        end
        PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EL_SKIP, PH_SN_SKIP5: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            case (phase_q)
              PH_SID_SKIP: phase_d = PH_CS_HI;
              PH_CS_SKIP:  phase_d = PH_CM_LEN;
              PH_CM_SKIP:  phase_d = PH_EXT_HI;
              PH_EL_SKIP: begin
                if (ext_search_q < ext_total_q) begin
                  phase_d = PH_ET_HI;
                end else begin
                  pkt_status_d = ST_NO_SNI;
                  phase_d      = PH_DONE;
                end
              end
              default:     phase_d = PH_NL_HI;
            endcase
          end
        end
        PH_EXT_LO: begin
          ext_total_d  = word;
          ext_search_d = 16'd0;
          if (word == 16'd0) begin
            pkt_status_d = ST_NO_EXT;
            phase_d      = PH_DONE;
          end else begin
            phase_d = PH_ET_HI;
          end
        end
        PH_ET_LO: begin
          if (word == 16'd0) begin
            skip_d  = SNI_HDR_SKIP;
            phase_d = PH_SN_SKIP5;
          end else begin
            phase_d = PH_EL_HI;
          end
        end
        PH_EL_LO: begin
          ext_search_d = search_sat;
          skip_d       = word;
          if (word != 16'd0) begin
            phase_d = PH_EL_SKIP;
          end else if (search_sat < ext_total_q) begin
            phase_d = PH_ET_HI;
          end else begin
            pkt_status_d = ST_NO_SNI;
            phase_d      = PH_DONE;
          end
        end
        PH_NL_LO: begin
          if (word == 16'd0) begin
            pkt_status_d = ST_NO_SNI;
            phase_d      = PH_DONE;
          end else if (word > 16'(MAX_NAME_BYTES)) begin
            name_rem_d   = NameW'(MAX_NAME_BYTES);
            pkt_status_d = ST_NAME_CUT;
            phase_d      = PH_NAME;
          end else begin
            name_rem_d   = word[NameW-1:0];
            pkt_status_d = ST_FOUND;
            phase_d      = PH_NAME;
          end
        end
        PH_NAME: begin
          name_rem_d = name_rem_q - NameW'(1);
          name_vld   = 1'b1;
          name_fin   = (name_rem_q == NameW'(1)) | eop;
          if (name_rem_q == NameW'(1)) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      // end of packet: status from the updated phase, then start afresh
      if (eop) begin
        if (phase_d == PH_DONE) begin
          end_status = pkt_status_d;
        end else if (phase_d inside {[PH_ET_HI:PH_EL_SKIP]}) begin
          end_status = ST_NO_SNI;
        end else if (phase_d inside {[PH_SN_SKIP5:PH_NAME]}) begin
          end_status = ST_NAME_CUT;
        end else begin
          end_status = ST_SHORT;
        end
        phase_d      = PH_TYPE;
        offset_d     = '0;
        skip_d       = '0;
        acc_d        = '0;
        ext_total_d  = '0;
        ext_search_d = '0;
        name_rem_d   = '0;
        pkt_status_d = ST_FOUND;
      end
    end
  end

  always_comb begin
    name_item.item_kind    = KIND_NAME;
    name_item.name_byte    = b;
    name_item.name_final   = name_fin;
    name_item.status       = ST_FOUND;
    status_item.item_kind  = KIND_STATUS;
    status_item.name_byte  = 8'd0;
    status_item.name_final = 1'b0;
    status_item.status     = end_status;
  end

  // queue pointers and fill count
  always_comb begin
    push_n   = {1'b0, name_vld} + {1'b0, in_fire & eop};
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_n);
    rd_ptr_d = rd_ptr_q + QPTR_W'(out_fire);
    count_d  = count_q + QCNT_W'(push_n) - QCNT_W'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      offset_q     <= '0;
      skip_q       <= '0;
      acc_q        <= '0;
      ext_total_q  <= '0;
      ext_search_q <= '0;
      name_rem_q   <= '0;
      pkt_status_q <= ST_FOUND;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      offset_q     <= offset_d;
      skip_q       <= skip_d;
      acc_q        <= acc_d;
      ext_total_q  <= ext_total_d;
      ext_search_q <= ext_search_d;
      name_rem_q   <= name_rem_d;
      pkt_status_q <= pkt_status_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
    end
  end

  // queue storage: name byte first, status behind it
  always_ff @(posedge clk_i) begin
    if (name_vld) begin
      queue_q[wr_ptr_q] <= name_item;
      if (eop) begin
        queue_q[wr_ptr_q + QPTR_W'(1)] <= status_item;
      end
    end else if (in_fire && eop) begin
      queue_q[wr_ptr_q] <= status_item;
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the tls server name extractor
// drives byte streams and checks every result against a local parser or a typed status; needs tls_sni_pkg
`default_nettype none

module testbench;
  import tls_sni_pkg::*;

  localparam int unsigned NAME_CAP     = MAX_NAME_BYTES_DEF;
  localparam int unsigned ITEM_TARGET  = 1350;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned STALL_LIMIT  = 3000;

  // flavors of generated client hello packets
  typedef enum {HELLO_RANDOM, HELLO_CLEAN} hello_kind_e;

  // one row of the directed table; st is only meaningful when typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       typed;
    status_e    st;
  } directed_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // status typed into the directed table travels next to the item it belongs to
  logic      in_typed        = 1'b0;
  status_e   in_typed_status = ST_FOUND;

  // traffic shaping
  bit        tx_idle_en = 1'b1;
  logic      rx_idle_en = 1'b1;
  logic      rx_hold    = 1'b0;
  logic      hold_go    = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // results the parser model says are still to come, oldest first
  out_item_t   sni_items_due [$];
  out_item_t   head_item;
  out_item_t   typed_item;

  // packet under construction
  logic [7:0]  pkt_bytes [$];
  logic [7:0]  ext_bytes [$];

  // parser model state
  phase_e      sni_phase;
  logic [15:0] hdr_offset;
  logic [15:0] skip_left;
  logic [7:0]  len_hi;
  logic [15:0] ext_total;
  logic [15:0] ext_searched;
  logic [15:0] name_left;
  status_e     pkt_status;
  out_item_t   step_items [2];
  int          step_count;

  // directed part: header checks and early ends; the last byte of each packet
  // has its status typed in, the bytes before it are checked by the model
  directed_row_t directed_rows [26] = '{
    // record type below the valid range
    {8'd0, 1'b1, 1'b1, ST_NOT_TLS},
    // record type above the valid range
    {8'd255, 1'b1, 1'b1, ST_NOT_TLS},
    // handshake record that ends right after its type
    {REC_TYPE_HANDSHK, 1'b1, 1'b1, ST_SHORT},
    // application data with a good version
    {REC_TYPE_APPDATA, 1'b0, 1'b0, ST_FOUND},
    {TLS_MAJOR_MIN, 1'b1, 1'b1, ST_APP_DATA},
    // lowest record type is not a handshake
    {REC_TYPE_MIN, 1'b0, 1'b0, ST_FOUND},
    {8'd255, 1'b1, 1'b1, ST_NOT_HANDSHAKE},
    // handshake with a version below 3
    {REC_TYPE_HANDSHK, 1'b0, 1'b0, ST_FOUND},
    {8'd2, 1'b1, 1'b1, ST_OLD_VERSION},
    // packet ends before the handshake type byte
    {REC_TYPE_HANDSHK, 1'b0, 1'b0, ST_FOUND},
    {TLS_MAJOR_MIN, 1'b0, 1'b0, ST_FOUND},
    {8'd0, 1'b0, 1'b0, ST_FOUND},
    {8'd255, 1'b0, 1'b0, ST_FOUND},
    {8'd0, 1'b1, 1'b1, ST_SHORT},
    // handshake type byte is not a client hello
    {REC_TYPE_HANDSHK, 1'b0, 1'b0, ST_FOUND},
    {TLS_MAJOR_MIN, 1'b0, 1'b0, ST_FOUND},
    {8'd0, 1'b0, 1'b0, ST_FOUND},
    {8'd0, 1'b0, 1'b0, ST_FOUND},
    {8'd0, 1'b0, 1'b0, ST_FOUND},
    {8'd2, 1'b1, 1'b1, ST_NOT_HELLO},
    // client hello that ends on its type byte
    {REC_TYPE_HANDSHK, 1'b0, 1'b0, ST_FOUND},
    {TLS_MAJOR_MIN, 1'b0, 1'b0, ST_FOUND},
    {8'd255, 1'b0, 1'b0, ST_FOUND},
    {8'd255, 1'b0, 1'b0, ST_FOUND},
    {8'd255, 1'b0, 1'b0, ST_FOUND},
    {HS_CLIENT_HELLO, 1'b1, 1'b1, ST_SHORT}
  };

  tls_sni_extractor_top #(
    .MAX_NAME_BYTES(NAME_CAP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    sni_phase    = PH_TYPE;
    hdr_offset   = '0;
    skip_left    = '0;
    len_hi       = '0;
    ext_total    = '0;
    ext_searched = '0;
    name_left    = '0;
    pkt_status   = ST_FOUND;
  endfunction

  // decision made; the rest of the packet is ignored
  function automatic void close_packet(input status_e s);
    pkt_status = s;
    sni_phase  = PH_DONE;
  endfunction

  // a zero length skips straight to the next field
  function automatic void begin_skip(input logic [15:0] len, input phase_e skip_ph,
                                     input phase_e next_ph);
    skip_left = len;
    sni_phase = (len == 16'd0) ? next_ph : skip_ph;
  endfunction

  function automatic void next_extension();
    if (ext_searched < ext_total) sni_phase = PH_ET_HI;
    else close_packet(ST_NO_SNI);
  endfunction

  // status for a packet that ends in the current phase
  function automatic status_e packet_end_status();
    if (sni_phase == PH_DONE) return pkt_status;
    if (sni_phase >= PH_ET_HI && sni_phase <= PH_EL_SKIP) return ST_NO_SNI;
    if (sni_phase >= PH_SN_SKIP5) return ST_NAME_CUT;
    return ST_SHORT;
  endfunction

  // advances the model by one byte; results land in step_items[0 .. step_count-1]
  task automatic parse_tls_byte(input in_item_t it);
    logic [7:0]  b;
    logic [15:0] word;
    logic [17:0] sum;
    b = it.data_byte;
    word = {len_hi, b};
    step_count = 0;
    case (sni_phase)
      PH_TYPE: begin
        if (b < REC_TYPE_MIN || b > REC_TYPE_MAX) begin
          close_packet(ST_NOT_TLS);
        end else if (b == REC_TYPE_HANDSHK) begin
          sni_phase = PH_VER_HS;
        end else begin
          pkt_status = (b == REC_TYPE_APPDATA) ? ST_APP_DATA : ST_NOT_HANDSHAKE;
          sni_phase  = PH_VER_OTHER;
        end
      end
      PH_VER_HS, PH_VER_OTHER: begin
        if (b < TLS_MAJOR_MIN) begin
          close_packet(ST_OLD_VERSION);
        end else if (sni_phase == PH_VER_OTHER) begin
          close_packet(pkt_status);
        end else begin
          hdr_offset = 16'(OFS_FIRST_HDR);
          sni_phase  = PH_HDR;
        end
      end
      PH_HDR: begin
        if (hdr_offset == OFS_HS_TYPE && b != HS_CLIENT_HELLO) begin
          close_packet(ST_NOT_HELLO);
        end else begin
          if (hdr_offset >= OFS_PREFIX_END) sni_phase = PH_SID_LEN;
          hdr_offset = hdr_offset + 16'd1;
        end
      end
      PH_SID_LEN: begin_skip({8'd0, b}, PH_SID_SKIP, PH_CS_HI);
      PH_CS_HI, PH_EXT_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI: begin
        len_hi    = b;
        sni_phase = phase_e'(sni_phase + 5'd1);
      end
      PH_CS_LO: begin_skip(word, PH_CS_SKIP, PH_CM_LEN);
      PH_CM_LEN: begin_skip({8'd0, b}, PH_CM_SKIP, PH_EXT_HI);
      PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EL_SKIP, PH_SN_SKIP5: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          case (sni_phase)
            PH_SID_SKIP: sni_phase = PH_CS_HI;
            PH_CS_SKIP:  sni_phase = PH_CM_LEN;
            PH_CM_SKIP:  sni_phase = PH_EXT_HI;
            PH_EL_SKIP:  next_extension();
            default:     sni_phase = PH_NL_HI;
          endcase
        end
      end
      PH_EXT_LO: begin
        ext_total    = word;
        ext_searched = '0;
        if (word == 16'd0) close_packet(ST_NO_EXT);
        else sni_phase = PH_ET_HI;
      end
      PH_ET_LO: begin
        if (word == 16'd0) begin
          skip_left = SNI_HDR_SKIP;
          sni_phase = PH_SN_SKIP5;
        end else begin
          sni_phase = PH_EL_HI;
        end
      end
      PH_EL_LO: begin
        // searched count saturates instead of wrapping
        sum = ext_searched + word + EXT_HDR_BYTES;
        ext_searched = (sum > SEARCH_SAT) ? SEARCH_SAT : sum[15:0];
        skip_left = word;
        if (word == 16'd0) next_extension();
        else sni_phase = PH_EL_SKIP;
      end
      PH_NL_LO: begin
        if (word == 16'd0) begin
          close_packet(ST_NO_SNI);
        end else begin
          if (word > NAME_CAP) begin
            name_left  = 16'(NAME_CAP);
            pkt_status = ST_NAME_CUT;
          end else begin
            name_left  = word;
            pkt_status = ST_FOUND;
          end
          sni_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        name_left = name_left - 16'd1;
        step_items[0].item_kind  = KIND_NAME;
        step_items[0].name_byte  = b;
        step_items[0].name_final = (name_left == 16'd0) || it.end_of_packet;
        step_items[0].status     = ST_FOUND;
        step_count = 1;
        if (name_left == 16'd0) sni_phase = PH_DONE;
      end
      default: ;
    endcase
    if (it.end_of_packet) begin
      step_items[step_count].item_kind  = KIND_STATUS;
      step_items[step_count].name_byte  = 8'd0;
      step_items[step_count].name_final = 1'b0;
      step_items[step_count].status     = packet_end_status();
      step_count++;
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // packet generation
  // ---------------------------------------------------------------------------

  // some extension other than server name, never type zero
  task automatic add_other_extension();
    int unsigned ext_type;
    int unsigned ext_len;
    ext_type = $urandom_range(1, 16'hFFFF);
    ext_len  = $urandom_range(5);
    ext_bytes.push_back(8'(ext_type >> 8));
    ext_bytes.push_back(8'(ext_type));
    ext_bytes.push_back(8'd0);
    ext_bytes.push_back(8'(ext_len));
    repeat (ext_len) ext_bytes.push_back(8'($urandom_range(255)));
  endtask

  // client hello with random content; clean ones always carry a name of 8 or
  // more bytes
  task automatic build_hello(input hello_kind_e kind);
    int unsigned sid_len;
    int unsigned cs_len;
    int unsigned cm_len;
    int unsigned name_len;
    int unsigned total;
    int unsigned roll;
    int unsigned cut;
    pkt_bytes.delete();
    ext_bytes.delete();
    pkt_bytes.push_back(REC_TYPE_HANDSHK);
    pkt_bytes.push_back((kind == HELLO_RANDOM && $urandom_range(9) == 0) ?
                        8'($urandom_range(255)) : TLS_MAJOR_MIN);
    repeat (3) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back((kind == HELLO_RANDOM && $urandom_range(9) == 0) ?
                        8'($urandom_range(255)) : HS_CLIENT_HELLO);
    // rest of the fixed prefix up to the session id length
    repeat (37) pkt_bytes.push_back(8'($urandom_range(255)));
    sid_len = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 32);
    pkt_bytes.push_back(8'(sid_len));
    repeat (sid_len) pkt_bytes.push_back(8'($urandom_range(255)));
    cs_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
    pkt_bytes.push_back(8'(cs_len >> 8));
    pkt_bytes.push_back(8'(cs_len));
    repeat (cs_len) pkt_bytes.push_back(8'($urandom_range(255)));
    cm_len = $urandom_range(3);
    pkt_bytes.push_back(8'(cm_len));
    repeat (cm_len) pkt_bytes.push_back(8'($urandom_range(255)));

    repeat ($urandom_range(2)) add_other_extension();

    if (kind != HELLO_RANDOM || $urandom_range(99) < 85) begin
      ext_bytes.push_back(8'd0);
      ext_bytes.push_back(8'd0);
      // extension length, list length and name type are skipped
      repeat (5) ext_bytes.push_back(8'($urandom_range(255)));
      roll = $urandom_range(99);
      if (kind != HELLO_RANDOM) name_len = $urandom_range(8, 24);
      else if (roll < 10) name_len = 0;
      else if (roll < 20) name_len = $urandom_range(NAME_CAP, 300);
      else name_len = $urandom_range(1, 24);
      ext_bytes.push_back(8'(name_len >> 8));
      ext_bytes.push_back(8'(name_len));
      repeat (name_len) ext_bytes.push_back(8'($urandom_range(255)));
    end
    if (kind == HELLO_RANDOM) repeat ($urandom_range(1)) add_other_extension();

    // extensions length: mostly right, sometimes zero or too short
    roll = $urandom_range(99);
    if (kind == HELLO_CLEAN || roll < 80) total = ext_bytes.size();
    else if (roll < 90) total = 0;
    else total = $urandom_range(1, ext_bytes.size());
    pkt_bytes.push_back(8'(total >> 8));
    pkt_bytes.push_back(8'(total));
    foreach (ext_bytes[i]) pkt_bytes.push_back(ext_bytes[i]);

    if (kind == HELLO_RANDOM) begin
      repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
      // cut short at a random point
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end
  endtask

  // short junk packets, often with a plausible record type
  task automatic build_noise();
    int unsigned len;
    pkt_bytes.delete();
    len = $urandom_range(1, 6);
    pkt_bytes.push_back(8'($urandom_range(1) ? $urandom_range(18, 26) : $urandom_range(255)));
    repeat (len - 1)
      pkt_bytes.push_back(8'(($urandom_range(9) < 5) ? $urandom_range(4) : $urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // random gaps first, then hold the item until the block takes it
  task automatic offer_item(input in_item_t it, input logic typed, input status_e st);
    while (tx_idle_en && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_item_i       <= it;
    in_typed        <= typed;
    in_typed_status <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_packet();
    in_item_t it;
    foreach (pkt_bytes[i]) begin
      it.data_byte     = pkt_bytes[i];
      it.end_of_packet = (i == pkt_bytes.size() - 1);
      offer_item(it, 1'b0, ST_FOUND);
    end
  endtask

  // stop offering until every predicted result has come out
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sni_items_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pkt_no;
    int unsigned items_sent;
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer_item({directed_rows[i].data, directed_rows[i].eop}, directed_rows[i].typed,
                 directed_rows[i].st);
    pause_until_drained();

    items_sent = $size(directed_rows);
    pkt_no = 0;
    while (items_sent < ITEM_TARGET) begin
      pkt_no++;
      // packet 1 runs under the long receiver hold with no sender gaps;
      // packets 5 to 9 run with no idling on either side
      tx_idle_en = !(pkt_no == 1 || (pkt_no >= 5 && pkt_no <= 9));
      rx_idle_en <= !(pkt_no >= 5 && pkt_no <= 9);
      if (pkt_no == 1) begin
        build_hello(HELLO_CLEAN);
        hold_go <= 1'b1;
      end else if ($urandom_range(99) < 65) begin
        build_hello(HELLO_RANDOM);
      end else begin
        build_noise();
      end
      send_packet();
      items_sent += pkt_bytes.size();
      if (pkt_no == 12) pause_until_drained();
    end

    pause_until_drained();
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver
  // ---------------------------------------------------------------------------

  // one long stall so the result queue fills and the input side backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(99) < 20) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // accepted input items feed the model, accepted result items are compared
  // with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        parse_tls_byte(in_item_i);
        if (in_typed) begin
          typed_item.item_kind  = KIND_STATUS;
          typed_item.name_byte  = 8'd0;
          typed_item.name_final = 1'b0;
          typed_item.status     = in_typed_status;
          sni_items_due.push_back(typed_item);
        end else begin
          for (int k = 0; k < step_count; k++) sni_items_due.push_back(step_items[k]);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (sni_items_due.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing due", out_item_o));
        end else begin
          head_item = sni_items_due.pop_front();
          if (out_item_o.item_kind !== head_item.item_kind)
            report_mismatch($sformatf("item_kind got %b want %b",
                                      out_item_o.item_kind, head_item.item_kind));
          if (out_item_o.name_byte !== head_item.name_byte)
            report_mismatch($sformatf("name_byte got %h want %h",
                                      out_item_o.name_byte, head_item.name_byte));
          if (out_item_o.name_final !== head_item.name_final)
            report_mismatch($sformatf("name_final got %b want %b",
                                      out_item_o.name_final, head_item.name_final));
          if (out_item_o.status !== head_item.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_item_o.status, head_item.status));
        end
      end
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
